/* rtl/swsq_pkg.sv */
`timescale 1ns / 1ps
// swsq_pkg: shared types and constants of the sensor wash sequencer.
// No dependencies; used by the core and by its checker.
package swsq_pkg;

    // Phase of the wash sequence, one-hot
    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_PARK   = 7'b0000010,
        PH_AIR1   = 7'b0000100,
        PH_PAUSE1 = 7'b0001000,
        PH_WASH   = 7'b0010000,
        PH_PAUSE2 = 7'b0100000,
        PH_AIR2   = 7'b1000000
    } phase_t;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_WASH_CYCLES      = 3'd0,
        REG_DRY_CYCLES       = 3'd1,
        REG_WIGGLE_ANGLE     = 3'd2,
        REG_WIGGLE_SPEED     = 3'd3,
        REG_PARK_SPEED       = 3'd4,
        REG_ARRIVE_TOLERANCE = 3'd5,
        REG_MOVE_TIMEOUT     = 3'd6
    } reg_idx_t;

    // Finish codes
    localparam logic [1:0] FIN_NONE = 2'd0;
    localparam logic [1:0] FIN_OK   = 2'd1;
    localparam logic [1:0] FIN_FAIL = 2'd2;

    // Wiggle legs
    localparam logic [1:0] LEG_NEG  = 2'd0;
    localparam logic [1:0] LEG_POS  = 2'd1;
    localparam logic [1:0] LEG_ZERO = 2'd2;

    // Valve bits: bit 0 washer, bit 1 air
    localparam logic [1:0] VALVE_OFF    = 2'b00;
    localparam logic [1:0] VALVE_WASHER = 2'b01;
    localparam logic [1:0] VALVE_AIR    = 2'b10;

    // Internal target: 0 or +/- wiggle angle (12 bits) as a signed value
    localparam int TGT_BITS   = 13;
    localparam int SPEED_BITS = 13;
    localparam int ANGLE_BITS = 12;

    // Result fields after tilt_target: speed, washer, air, busy, accepted, finish
    localparam int OUT_TAIL_BITS = SPEED_BITS + 6;

    // Register reset values
    localparam logic [2:0]  RST_WASH_CYCLES      = 3'd1;
    localparam logic [2:0]  RST_DRY_CYCLES       = 3'd4;
    localparam logic [11:0] RST_WIGGLE_ANGLE     = 12'd357;
    localparam logic [12:0] RST_WIGGLE_SPEED     = 13'd819;
    localparam logic [12:0] RST_PARK_SPEED       = 13'd819;
    localparam logic [11:0] RST_ARRIVE_TOLERANCE = 12'd41;
    localparam logic [7:0]  RST_MOVE_TIMEOUT     = 8'd20;

endpackage

/* rtl/sensor_wash_sequencer_core.sv */
`timescale 1ns / 1ps
// sensor_wash_sequencer_core: sequences the wash of a tilting sensor head.
// The result of an accepted input transaction is registered and offered in the next cycle.
// Throughput: one transaction per cycle unless the result side stalls; the whole step
// is one pass of logic between the sequence state registers and the result register.
// Reset (aresetn, synchronous, active low): phase idle, valves off, target zero,
// result channel empty, configuration registers at their documented defaults.
// Depends on swsq_pkg.
module sensor_wash_sequencer_core
    import swsq_pkg::*;
#(
    parameter int TILT_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,

    // Input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: [TILT_BITS-1:0] measured_tilt, [TILT_BITS] command_fault, zero pad
    input  logic [((TILT_BITS + 1 + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser: [0] opcode (0 wash request, 1 tick)
    input  logic [0:0]                             s_tuser,

    // Result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tdata: tilt_target, tilt_speed[12:0], washer_on, air_on, busy_res,
    //        accepted, finish_code[1:0], zero pad (lowest bit first)
    output logic [((TILT_BITS + OUT_TAIL_BITS + 7) / 8) * 8 - 1:0] m_tdata,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int OUT_W = ((TILT_BITS + OUT_TAIL_BITS + 7) / 8) * 8;
    // Width that holds measured - target without overflow
    localparam int DW = ((TILT_BITS > TGT_BITS) ? TILT_BITS : TGT_BITS) + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0]            wash_cycles_reg;
    logic [2:0]            dry_cycles_reg;
    logic [ANGLE_BITS-1:0] wiggle_angle_reg;
    logic [SPEED_BITS-1:0] wiggle_speed_reg;
    logic [SPEED_BITS-1:0] park_speed_reg;
    logic [11:0]           arrive_tol_reg;
    logic [7:0]            move_timeout_reg;

    reg_idx_t cfg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wash_cycles_reg  <= RST_WASH_CYCLES;
            dry_cycles_reg   <= RST_DRY_CYCLES;
            wiggle_angle_reg <= RST_WIGGLE_ANGLE;
            wiggle_speed_reg <= RST_WIGGLE_SPEED;
            park_speed_reg   <= RST_PARK_SPEED;
            arrive_tol_reg   <= RST_ARRIVE_TOLERANCE;
            move_timeout_reg <= RST_MOVE_TIMEOUT;
        end else if (cfg_wr) begin
            // An address past the last register is dropped
            case (cfg_idx)
                REG_WASH_CYCLES:      wash_cycles_reg  <= pwdata[2:0];
                REG_DRY_CYCLES:       dry_cycles_reg   <= pwdata[2:0];
                REG_WIGGLE_ANGLE:     wiggle_angle_reg <= pwdata[ANGLE_BITS-1:0];
                REG_WIGGLE_SPEED:     wiggle_speed_reg <= pwdata[SPEED_BITS-1:0];
                REG_PARK_SPEED:       park_speed_reg   <= pwdata[SPEED_BITS-1:0];
                REG_ARRIVE_TOLERANCE: arrive_tol_reg   <= pwdata[11:0];
                REG_MOVE_TIMEOUT:     move_timeout_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back: zero-extend the addressed register
    always_comb begin
        unique case (cfg_idx)
            REG_WASH_CYCLES:      prdata = 32'(wash_cycles_reg);
            REG_DRY_CYCLES:       prdata = 32'(dry_cycles_reg);
            REG_WIGGLE_ANGLE:     prdata = 32'(wiggle_angle_reg);
            REG_WIGGLE_SPEED:     prdata = 32'(wiggle_speed_reg);
            REG_PARK_SPEED:       prdata = 32'(park_speed_reg);
            REG_ARRIVE_TOLERANCE: prdata = 32'(arrive_tol_reg);
            REG_MOVE_TIMEOUT:     prdata = 32'(move_timeout_reg);
            default:              prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: the result register frees itself when taken, so a new
    // transaction enters in the same cycle the previous result leaves.
    // ------------------------------------------------------------------
    logic take;
    assign s_tready = !m_tvalid || m_tready;
    assign take     = s_tvalid && s_tready;

    // Unpack the input transaction
    logic                        in_tick;
    logic signed [TILT_BITS-1:0] in_tilt;
    logic                        in_fault;

    assign in_tick  = s_tuser[0];
    assign in_tilt  = $signed(s_tdata[TILT_BITS-1:0]);
    assign in_fault = s_tdata[TILT_BITS];

    // ------------------------------------------------------------------
    // Sequence state
    // ------------------------------------------------------------------
    phase_t                     phase_reg,  phase_next;
    logic [2:0]                 left_reg,   left_next;
    logic [1:0]                 leg_reg,    leg_next;
    logic [7:0]                 wait_reg,   wait_next;
    logic signed [TGT_BITS-1:0] target_reg, target_next;
    logic [1:0]                 valve_reg,  valve_next;

    // Arrival test: |measured - target| < tolerance, in a width that cannot wrap
    logic signed [DW-1:0] err;
    logic        [DW-1:0] err_abs;
    logic                 arrived;
    logic [7:0]           wait_inc;

    logic signed [TGT_BITS-1:0] pos_angle, neg_angle;

    assign pos_angle = $signed({1'b0, wiggle_angle_reg});
    assign neg_angle = -pos_angle;

    assign err      = DW'(in_tilt) - DW'(target_reg);
    assign err_abs  = err[DW-1] ? DW'(-err) : DW'(err);
    assign arrived  = err_abs < DW'(arrive_tol_reg);
    assign wait_inc = wait_reg + 8'd1;

    // Wiggle start request raised by the decision logic below
    logic       wig_start;
    phase_t     wig_phase;
    logic [2:0] wig_count;

    logic       acc;
    logic [1:0] fin_code;

    always_comb begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        leg_next    = leg_reg;
        wait_next   = wait_reg;
        target_next = target_reg;
        valve_next  = valve_reg;
        wig_start   = 1'b0;
        wig_phase   = PH_AIR1;
        wig_count   = dry_cycles_reg;
        acc         = 1'b0;
        fin_code    = FIN_NONE;

        if (!in_tick) begin
            // Wash request: start only from idle, ignore otherwise
            if (phase_reg == PH_IDLE) begin
                acc         = 1'b1;
                phase_next  = PH_PARK;
                valve_next  = VALVE_OFF;
                left_next   = 3'd0;
                leg_next    = LEG_NEG;
                target_next = '0;
                wait_next   = 8'd0;
            end
        end else if (phase_reg != PH_IDLE) begin
            if (in_fault) begin
                fin_code = FIN_FAIL;
            end else begin
                unique case (phase_reg)
                    PH_PAUSE1: begin
                        valve_next = VALVE_WASHER;
                        wig_start  = 1'b1;
                        wig_phase  = PH_WASH;
                        wig_count  = wash_cycles_reg;
                    end
                    PH_PAUSE2: begin
                        valve_next = VALVE_AIR;
                        wig_start  = 1'b1;
                        wig_phase  = PH_AIR2;
                        wig_count  = dry_cycles_reg;
                    end
                    default: begin
                        if (arrived) begin
                            if (phase_reg == PH_PARK) begin
                                valve_next = VALVE_AIR;
                                wig_start  = 1'b1;
                                wig_phase  = PH_AIR1;
                                wig_count  = dry_cycles_reg;
                            end else if (leg_reg == LEG_NEG) begin
                                leg_next    = LEG_POS;
                                target_next = pos_angle;
                                wait_next   = 8'd0;
                            end else if (leg_reg == LEG_POS) begin
                                left_next = left_reg - 3'd1;
                                wait_next = 8'd0;
                                if (left_reg != 3'd1) begin
                                    leg_next    = LEG_NEG;
                                    target_next = neg_angle;
                                end else begin
                                    leg_next    = LEG_ZERO;
                                    target_next = '0;
                                end
                            end else begin
                                // Back at zero: close the valves and end the phase
                                valve_next = VALVE_OFF;
                                wait_next  = 8'd0;
                                if (phase_reg == PH_AIR1) begin
                                    phase_next = PH_PAUSE1;
                                end else if (phase_reg == PH_WASH) begin
                                    phase_next = PH_PAUSE2;
                                end else begin
                                    fin_code = FIN_OK;
                                end
                            end
                        end else begin
                            wait_next = wait_inc;
                            if (wait_inc >= move_timeout_reg) begin
                                fin_code = FIN_FAIL;
                            end
                        end
                    end
                endcase
            end
        end

        // Enter a wiggle phase; a zero count goes straight to the return leg
        if (wig_start) begin
            phase_next = wig_phase;
            left_next  = wig_count;
            wait_next  = 8'd0;
            if (wig_count == 3'd0) begin
                leg_next    = LEG_ZERO;
                target_next = '0;
            end else begin
                leg_next    = LEG_NEG;
                target_next = neg_angle;
            end
        end

        // Sequence finished, either way: drop to idle with valves off
        if (fin_code != FIN_NONE) begin
            phase_next = PH_IDLE;
            valve_next = VALVE_OFF;
            left_next  = 3'd0;
            leg_next   = LEG_NEG;
            wait_next  = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            left_reg   <= 3'd0;
            leg_reg    <= LEG_NEG;
            wait_reg   <= 8'd0;
            target_reg <= '0;
            valve_reg  <= VALVE_OFF;
        end else if (take) begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            leg_reg    <= leg_next;
            wait_reg   <= wait_next;
            target_reg <= target_next;
            valve_reg  <= valve_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [SPEED_BITS-1:0] speed;
    logic [DW-1:0]         target_ext;
    logic                  busy;

    always_comb begin
        unique case (phase_next)
            PH_IDLE: speed = '0;
            PH_PARK: speed = park_speed_reg;
            default: speed = wiggle_speed_reg;
        endcase
    end

    // Sign-extend the target and keep the low TILT_BITS, as the port carries
    assign target_ext = DW'(target_next);
    assign busy       = phase_next != PH_IDLE;

    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_data_reg <= OUT_W'({fin_code, acc, busy, valve_next[1], valve_next[0],
                                  speed, target_ext[TILT_BITS-1:0]});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* rtl/swsq_checker.sv */
`timescale 1ns / 1ps
// swsq_checker: port-level assertions for sensor_wash_sequencer_core.
// Depends on swsq_pkg; bound to the core at the end of this file.
module swsq_checker
    import swsq_pkg::*;
#(
    parameter int TILT_BITS = 16
) (
    input logic aclk,
    input logic aresetn,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((TILT_BITS + OUT_TAIL_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int SPD_LO = TILT_BITS;
    localparam int WSH_B  = TILT_BITS + SPEED_BITS;
    localparam int AIR_B  = WSH_B + 1;
    localparam int BSY_B  = WSH_B + 2;
    localparam int ACC_B  = WSH_B + 3;
    localparam int FIN_LO = WSH_B + 4;

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A started wash reports busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[ACC_B] |-> m_tdata[BSY_B] && m_tdata[FIN_LO+1 -: 2] == FIN_NONE)
        else $error("accepted request not busy");

    // A finish leaves the head idle with valves off
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[FIN_LO+1 -: 2] != FIN_NONE
        |-> !m_tdata[BSY_B] && !m_tdata[WSH_B] && !m_tdata[AIR_B])
        else $error("finish with busy or valve on");

    // Idle means no speed and no valve
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[BSY_B]
        |-> m_tdata[SPD_LO +: SPEED_BITS] == '0 && !m_tdata[WSH_B] && !m_tdata[AIR_B])
        else $error("idle with speed or valve");

    // Input never stalls while the result side is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

bind sensor_wash_sequencer_core swsq_checker #(.TILT_BITS(TILT_BITS)) u_swsq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for sensor_wash_sequencer_core, with its own step model of
// the wash sequence, an APB register writer, a stream driver and a result monitor.
// Depends on swsq_pkg and sensor_wash_sequencer_core.
module testbench;
    import swsq_pkg::*;

    localparam int TILT_BITS = 16;
    localparam int S_W = ((TILT_BITS + 1 + 7) / 8) * 8;
    localparam int M_W = ((TILT_BITS + OUT_TAIL_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Register set as the sequencer sees it
    typedef struct packed {
        logic [2:0]  wash_n;
        logic [2:0]  dry_n;
        logic [11:0] angle;
        logic [12:0] wiggle_spd;
        logic [12:0] park_spd;
        logic [11:0] tol;
        logic [7:0]  timeout;
    } seq_cfg_t;

    // Sequencer state between transactions
    typedef struct packed {
        phase_t             ph;
        logic [2:0]         left;
        logic [1:0]         leg;
        logic [7:0]         waits;
        logic signed [15:0] tgt;
        logic [1:0]         valves;
    } seq_state_t;

    typedef struct packed {
        logic               op;
        logic signed [15:0] tilt;
        logic               fault;
    } wash_item_t;

    typedef struct packed {
        logic signed [15:0] target;
        logic [12:0]        speed;
        logic               washer;
        logic               air;
        logic               busy;
        logic               acc;
        logic [1:0]         fin;
    } head_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic           s_tvalid = 1'b0;
    logic           s_tready;
    // s_tdata: [15:0] measured_tilt, [16] command_fault, zero pad
    logic [S_W-1:0] s_tdata = '0;
    // s_tuser: [0] opcode
    logic [0:0]     s_tuser = '0;

    logic           m_tvalid;
    logic           m_tready = 1'b0;
    // m_tdata: [15:0] tilt_target, [28:16] tilt_speed, [29] washer_on, [30] air_on,
    //          [31] busy_res, [32] accepted, [34:33] finish_code, zero pad
    logic [M_W-1:0] m_tdata;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sensor_wash_sequencer_core #(
        .TILT_BITS(TILT_BITS)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #1 aclk = ~aclk;

    // Register copy used when a transaction is accepted; only written while the block is idle
    seq_cfg_t   live_cfg;
    // Two copies of the sequence state: one steers stimulus, one predicts at acceptance
    seq_state_t plan_state;
    seq_state_t model_state;

    wash_item_t   wash_traffic[$];
    head_report_t head_reports_due[$];
    wash_item_t   in_flight;

    int n_total = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;
    int cycles = 0;

    // Take a long stretch of the run with both sides streaming flat out
    logic quiet;
    assign quiet = (n_sent >= 150) && (n_sent < 260);

    function automatic void start_wiggle(inout seq_state_t st, input logic [2:0] count,
                                         input logic [11:0] angle);
        st.left  = count;
        st.waits = '0;
        if (count == 3'd0) begin
            // no wiggles: head straight for the return-to-zero leg
            st.leg = LEG_ZERO;
            st.tgt = '0;
        end else begin
            st.leg = LEG_NEG;
            st.tgt = -$signed({4'b0, angle});
        end
    endfunction

    // Advance the sequence by one transaction and return the command report it causes
    function automatic head_report_t sequence_step(inout seq_state_t st, input seq_cfg_t c,
                                                   input wash_item_t it);
        head_report_t r;
        int           err;
        r = '0;
        if (it.op == OP_REQUEST) begin
            if (st.ph == PH_IDLE) begin
                r.acc     = 1'b1;
                st.ph     = PH_PARK;
                st.valves = VALVE_OFF;
                st.left   = '0;
                st.leg    = LEG_NEG;
                st.tgt    = '0;
                st.waits  = '0;
            end
        end else if (st.ph != PH_IDLE) begin
            if (it.fault) begin
                r.fin = FIN_FAIL;
            end else if (st.ph == PH_PAUSE1) begin
                st.valves = VALVE_WASHER;
                st.ph     = PH_WASH;
                start_wiggle(st, c.wash_n, c.angle);
            end else if (st.ph == PH_PAUSE2) begin
                st.valves = VALVE_AIR;
                st.ph     = PH_AIR2;
                start_wiggle(st, c.dry_n, c.angle);
            end else begin
                err = int'($signed(it.tilt)) - int'($signed(st.tgt));
                if (err < 0) begin
                    err = -err;
                end
                if (err < int'(c.tol)) begin
                    if (st.ph == PH_PARK) begin
                        st.valves = VALVE_AIR;
                        st.ph     = PH_AIR1;
                        start_wiggle(st, c.dry_n, c.angle);
                    end else if (st.leg == LEG_NEG) begin
                        st.leg   = LEG_POS;
                        st.tgt   = $signed({4'b0, c.angle});
                        st.waits = '0;
                    end else if (st.leg == LEG_POS) begin
                        st.left  = st.left - 3'd1;
                        st.waits = '0;
                        if (st.left != 3'd0) begin
                            st.leg = LEG_NEG;
                            st.tgt = -$signed({4'b0, c.angle});
                        end else begin
                            st.leg = LEG_ZERO;
                            st.tgt = '0;
                        end
                    end else begin
                        // back at zero: close the valves and move on
                        st.valves = VALVE_OFF;
                        st.waits  = '0;
                        if (st.ph == PH_AIR1) begin
                            st.ph = PH_PAUSE1;
                        end else if (st.ph == PH_WASH) begin
                            st.ph = PH_PAUSE2;
                        end else begin
                            r.fin = FIN_OK;
                        end
                    end
                end else begin
                    st.waits = st.waits + 8'd1;
                    if (st.waits >= c.timeout) begin
                        r.fin = FIN_FAIL;
                    end
                end
            end
            if (r.fin != FIN_NONE) begin
                // target is held; everything else drops back to idle
                st.ph     = PH_IDLE;
                st.valves = VALVE_OFF;
                st.left   = '0;
                st.leg    = LEG_NEG;
                st.waits  = '0;
            end
        end
        r.target = st.tgt;
        if (st.ph == PH_IDLE) begin
            r.speed = '0;
        end else if (st.ph == PH_PARK) begin
            r.speed = c.park_spd;
        end else begin
            r.speed = c.wiggle_spd;
        end
        r.washer = st.valves[0];
        r.air    = st.valves[1];
        r.busy   = (st.ph != PH_IDLE);
        return r;
    endfunction

    function automatic void compare_field(string name, int want, int got);
        if (want != got) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Driver: present queued transactions, predict each one as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                head_reports_due.push_back(sequence_step(model_state, live_cfg, in_flight));
                n_sent <= n_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (wash_traffic.size() != 0 && (quiet || $urandom_range(0, 99) >= 29)) begin
                    in_flight = wash_traffic.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_W - TILT_BITS - 1){1'b0}}, in_flight.fault, in_flight.tilt};
                    s_tuser  <= in_flight.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall the result side at random and check every accepted report in order
    always @(posedge aclk) begin
        head_report_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= 29);
            if (m_tvalid && m_tready) begin
                n_checked <= n_checked + 1;
                if (head_reports_due.size() == 0) begin
                    n_errors++;
                    $display("%0t: result transaction with nothing expected, actual %h",
                             $time, m_tdata);
                end else begin
                    want = head_reports_due.pop_front();
                    compare_field("tilt_target", int'(want.target),
                                  int'($signed(m_tdata[15:0])));
                    compare_field("tilt_speed", int'(want.speed), int'(m_tdata[28:16]));
                    compare_field("washer_on", int'(want.washer), int'(m_tdata[29]));
                    compare_field("air_on", int'(want.air), int'(m_tdata[30]));
                    compare_field("busy_res", int'(want.busy), int'(m_tdata[31]));
                    compare_field("accepted", int'(want.acc), int'(m_tdata[32]));
                    compare_field("finish_code", int'(want.fin), int'(m_tdata[34:33]));
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_config(input seq_cfg_t c);
        write_reg(REG_WASH_CYCLES, 32'(c.wash_n));
        write_reg(REG_DRY_CYCLES, 32'(c.dry_n));
        write_reg(REG_WIGGLE_ANGLE, 32'(c.angle));
        write_reg(REG_WIGGLE_SPEED, 32'(c.wiggle_spd));
        write_reg(REG_PARK_SPEED, 32'(c.park_spd));
        write_reg(REG_ARRIVE_TOLERANCE, 32'(c.tol));
        write_reg(REG_MOVE_TIMEOUT, 32'(c.timeout));
        live_cfg = c;
    endtask

    // Hold until every queued transaction has come back, then let the pipeline settle
    task automatic wait_drained(input int settle);
        while (n_checked < n_total) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic queue_item(input logic op, input int tilt, input logic fault);
        wash_item_t it;
        it.op    = op;
        it.tilt  = 16'(tilt);
        it.fault = fault;
        void'(sequence_step(plan_state, live_cfg, it));
        wash_traffic.push_back(it);
        n_total++;
    endtask

    // Mostly well-formed washes: ticks that land within tolerance of the current target,
    // salted with stray requests, faults and wild tilt readings
    task automatic fill_random(input int count);
        int roll;
        int off;
        int tol;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            tol  = int'(live_cfg.tol);
            if (plan_state.ph == PH_IDLE) begin
                if (roll < 85) begin
                    queue_item(OP_REQUEST, $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
                end else begin
                    queue_item(OP_TICK, $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
                end
            end else if (roll < 4) begin
                queue_item(OP_REQUEST, $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
            end else if (roll < 7) begin
                queue_item(OP_TICK, $urandom_range(0, 65535), 1'b1);
            end else if (roll < 85 && tol > 0) begin
                off = $urandom_range(0, 2 * tol - 2);
                off = off - (tol - 1);
                queue_item(OP_TICK, int'($signed(plan_state.tgt)) + off, 1'b0);
            end else begin
                queue_item(OP_TICK, $urandom_range(0, 65535), 1'b0);
            end
        end
        // drop any sequence still running so that the next register write finds it idle
        if (plan_state.ph != PH_IDLE) begin
            queue_item(OP_TICK, 0, 1'b1);
        end
    endtask

    function automatic seq_cfg_t random_config();
        seq_cfg_t c;
        c.wash_n     = 3'($urandom_range(0, 7));
        c.dry_n      = 3'($urandom_range(0, 7));
        c.angle      = 12'($urandom_range(0, 4095));
        c.wiggle_spd = 13'($urandom_range(0, 8191));
        c.park_spd   = 13'($urandom_range(0, 8191));
        c.tol        = ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 200))
                                                   : 12'($urandom_range(0, 4095));
        c.timeout    = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 30))
                                                   : 8'($urandom_range(0, 255));
        return c;
    endfunction

    initial begin
        seq_cfg_t reset_cfg;
        seq_cfg_t c;

        reset_cfg = '{wash_n: RST_WASH_CYCLES, dry_n: RST_DRY_CYCLES,
                      angle: RST_WIGGLE_ANGLE, wiggle_spd: RST_WIGGLE_SPEED,
                      park_spd: RST_PARK_SPEED, tol: RST_ARRIVE_TOLERANCE,
                      timeout: RST_MOVE_TIMEOUT};
        live_cfg    = reset_cfg;
        plan_state  = '{ph: PH_IDLE, leg: LEG_NEG, valves: VALVE_OFF, default: '0};
        model_state = plan_state;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: idle ticks at the tilt extremes, a busy request, the tolerance
        // boundary, a move that has not arrived, then a fault
        queue_item(OP_TICK, 32767, 1'b1);
        queue_item(OP_TICK, -32768, 1'b0);
        queue_item(OP_REQUEST, 32'h0000_5a5a, 1'b1);
        queue_item(OP_REQUEST, 0, 1'b0);
        queue_item(OP_TICK, 32767, 1'b0);
        queue_item(OP_TICK, 0, 1'b0);
        queue_item(OP_TICK, -357 + 40, 1'b0);
        queue_item(OP_TICK, 357 - 41, 1'b0);
        queue_item(OP_TICK, 357, 1'b1);
        wait_drained(4);

        // Zero wiggle counts, zero timeout, widest tolerance: a fault in a pause,
        // an instant timeout and a complete successful wash
        load_config('{wash_n: 3'd0, dry_n: 3'd0, angle: 12'd4095, wiggle_spd: 13'd8191,
                      park_spd: 13'd0, tol: 12'd4095, timeout: 8'd0});
        queue_item(OP_REQUEST, 0, 1'b0);
        queue_item(OP_TICK, 4094, 1'b0);
        queue_item(OP_TICK, -4094, 1'b0);
        queue_item(OP_TICK, 0, 1'b0);
        queue_item(OP_TICK, 0, 1'b0);
        queue_item(OP_TICK, 0, 1'b1);
        queue_item(OP_REQUEST, 0, 1'b0);
        queue_item(OP_TICK, 4095, 1'b0);
        queue_item(OP_REQUEST, 0, 1'b0);
        queue_item(OP_TICK, 0, 1'b0);
        queue_item(OP_TICK, 0, 1'b0);
        queue_item(OP_TICK, 0, 1'b0);
        queue_item(OP_TICK, 0, 1'b0);
        queue_item(OP_TICK, 0, 1'b0);
        queue_item(OP_TICK, 0, 1'b0);
        wait_drained(4);

        // Random washes across the upper extremes, the lower extremes, the reset values
        // and a few random settings
        load_config('{wash_n: 3'd5, dry_n: 3'd5, angle: 12'd4095, wiggle_spd: 13'd8191,
                      park_spd: 13'd8191, tol: 12'd4095, timeout: 8'd255});
        fill_random(75);
        wait_drained(4);
        load_config('{wash_n: 3'd1, dry_n: 3'd1, angle: 12'd0, wiggle_spd: 13'd0,
                      park_spd: 13'd0, tol: 12'd1, timeout: 8'd1});
        fill_random(75);
        wait_drained(4);
        load_config(reset_cfg);
        fill_random(75);
        wait_drained(4);
        repeat (3) begin
            c = random_config();
            load_config(c);
            fill_random(75);
            wait_drained(4);
        end

        wait_drained(20);
        if (head_reports_due.size() != 0) begin
            n_errors++;
            $display("%0t: %0d expected results never arrived", $time, head_reports_due.size());
        end
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/swsq_pkg.sv
rtl/sensor_wash_sequencer_core.sv
rtl/swsq_checker.sv
tb/sv/testbench.sv
